@@ rtl/mlc_pkg.sv @@
`default_nettype none
package mlc_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);
  localparam int WrapTop = 9;

  localparam logic signed [25:0] YawReset = -26'sd5898240;
  localparam logic signed [23:0] PitchReset = -24'sd3932160;
  localparam logic signed [31:0] PosYReset = 32'sd3932160;
  localparam logic signed [26:0] HalfTurn = 27'sd11796480;
  localparam logic signed [26:0] FullTurn = 27'sd23592960;
  localparam logic signed [26:0] QuarterTurn = 27'sd5898240;
  localparam logic signed [33:0] PitchLimit = 34'sd5832704;
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;

  localparam logic [2:0] ModeMouse = 3'd0;
  localparam logic [2:0] ModeFwd = 3'd1;
  localparam logic [2:0] ModeBack = 3'd2;
  localparam logic [2:0] ModeLeft = 3'd3;
  localparam logic [2:0] ModeRight = 3'd4;
  localparam logic [2:0] ModeUp = 3'd5;
  localparam logic [2:0] ModeDown = 3'd6;

  localparam logic CfgSens = 1'b0;
  localparam logic CfgSpeed = 1'b1;

  typedef struct packed {
    logic [2:0] mode;
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
    logic [15:0] delta_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ANGLE, S_WRAP, S_CYAW_START, S_CYAW, S_CPIT_START, S_CPIT,
    S_PROD, S_MOVE, S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic signed [26:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic busy;
    logic signed [15:0] s;
    logic signed [15:0] c;
  } cordic_rsp_t;

  function automatic logic signed [22:0] atan_deg(input logic [4:0] i);
    logic signed [22:0] r;
    case (i)
      5'd0: r = 23'sd2949120;
      5'd1: r = 23'sd1740967;
      5'd2: r = 23'sd919879;
      5'd3: r = 23'sd466945;
      5'd4: r = 23'sd234379;
      5'd5: r = 23'sd117304;
      5'd6: r = 23'sd58666;
      5'd7: r = 23'sd29335;
      5'd8: r = 23'sd14668;
      5'd9: r = 23'sd7334;
      5'd10: r = 23'sd3667;
      5'd11: r = 23'sd1833;
      5'd12: r = 23'sd917;
      5'd13: r = 23'sd458;
      5'd14: r = 23'sd229;
      5'd15: r = 23'sd115;
      5'd16: r = 23'sd57;
      5'd17: r = 23'sd29;
      5'd18: r = 23'sd14;
      5'd19: r = 23'sd7;
      5'd20: r = 23'sd4;
      5'd21: r = 23'sd2;
      5'd22: r = 23'sd1;
      default: r = 23'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) r = 16'sd32767;
    else if (v < -36'sd32768) r = -16'sd32768;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/mouse_look_camera_orientation_top.sv @@
// An accepted item passes S_ANGLE, then for a mouse item S_WRAP, where compare-and-subtract
// steps wrap yaw, then the two sine/cosine runs on the shared CORDIC (S_CYAW, S_CPIT),
// then S_PROD and S_MOVE, and the result is registered for output in S_DONE.
// A new item is not taken before the last one is done; input is ready only when idle,
// and a result still waiting in the output register holds the next item in its last state.
// Reset: synchronous active-high rst restores yaw -90, pitch -60, position (0,60,0),
// default sensitivity and speed, and the first-event flag.
`default_nettype none
module mouse_look_camera_orientation_top
  import mlc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire in_item_t in_data,
  output logic out_valid,
  input wire logic out_ready,
  output out_item_t out_data,
  input wire logic cfg_we,
  input wire logic cfg_index,
  input wire logic [15:0] cfg_wdata
);

  state_t state, state_next;
  in_item_t item;
  logic [15:0] sens, speed;
  logic signed [25:0] yaw;
  logic signed [23:0] pitch;
  logic signed [31:0] pos [3];
  logic [15:0] last_x, last_y;
  logic first;
  logic signed [15:0] sy, cy, sp, cp;
  logic signed [15:0] fx, fz, ux, uz;
  logic [3:0] wcnt;
  logic signed [35:0] wr, wsub, wr_next;
  cordic_req_t creq;
  cordic_rsp_t crsp;
  out_item_t view;

  mlc_cordic u_cordic (.clk(clk), .rst(rst), .req(creq), .rsp(crsp));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && in_ready) state_next = S_ANGLE;
      S_ANGLE: state_next = (item.mode == ModeMouse) ? S_WRAP : S_CYAW_START;
      S_WRAP: if (wcnt == '0) state_next = S_CYAW_START;
      S_CYAW_START: state_next = S_CYAW;
      S_CYAW: if (!crsp.busy) state_next = S_CPIT_START;
      S_CPIT_START: state_next = S_CPIT;
      S_CPIT: if (!crsp.busy) state_next = S_PROD;
      S_PROD: state_next = S_MOVE;
      S_MOVE: state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    creq.start = 1'b0;
    creq.angle = 27'(yaw);
    case (state)
      S_CYAW_START: begin
        creq.start = 1'b1;
        creq.angle = 27'(yaw);
      end
      S_CPIT_START: begin
        creq.start = 1'b1;
        creq.angle = 27'(pitch);
      end
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  logic signed [16:0] dxp, dyp;
  logic signed [34:0] dyaw, dpit;
  logic signed [35:0] ysum;
  logic signed [35:0] psum;
  logic [15:0] lx, ly;

  always_comb begin
    lx = first ? item.cursor_x : last_x;
    ly = first ? item.cursor_y : last_y;
    dxp = $signed({1'b0, item.cursor_x}) - $signed({1'b0, lx});
    dyp = $signed({1'b0, ly}) - $signed({1'b0, item.cursor_y});
    dyaw = dxp * $signed({1'b0, sens});
    dpit = dyp * $signed({1'b0, sens});
    ysum = 36'(yaw) + 36'(HalfTurn) + 36'(dyaw);
    psum = 36'(pitch) + 36'(dpit);
    wsub = wr - (36'(FullTurn) <<< wcnt);
    wr_next = wsub[35] ? wr : wsub;
  end

  function automatic logic signed [15:0] mul15(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    logic signed [35:0] p;
    p = 36'(a) * 36'(b) + 36'sd16384;
    return sat16(p >>> 15);
  endfunction

  function automatic logic signed [15:0] neg16(input logic signed [15:0] a);
    return (a == -16'sd32768) ? 16'sd32767 : -a;
  endfunction

  logic signed [16:0] dir [3];
  logic sub;
  logic mv;
  logic [31:0] k;
  logic signed [49:0] stp [3];
  logic signed [32:0] np [3];

  always_comb begin
    dir[0] = '0; dir[1] = '0; dir[2] = '0;
    sub = 1'b0; mv = 1'b1;
    case (item.mode)
      ModeFwd, ModeBack: begin
        dir[0] = 17'(fx); dir[1] = 17'(sp); dir[2] = 17'(fz);
        sub = (item.mode == ModeBack);
      end
      ModeLeft, ModeRight: begin
        dir[0] = 17'(neg16(sy)); dir[2] = 17'(cy);
        sub = (item.mode == ModeLeft);
      end
      ModeUp, ModeDown: begin
        dir[1] = 17'sd32768;
        sub = (item.mode == ModeDown);
      end
      default: mv = 1'b0;
    endcase
    for (int j = 0; j < 3; j++) begin
      stp[j] = (50'(dir[j]) * $signed({18'd0, k}) + 50'sd4194304) >>> 23;
      np[j] = sub ? 33'(pos[j]) - 33'(stp[j]) : 33'(pos[j]) + 33'(stp[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sens <= 16'd6554;
      speed <= 16'd1280;
      yaw <= YawReset;
      pitch <= PitchReset;
      pos[0] <= '0;
      pos[1] <= PosYReset;
      pos[2] <= '0;
      last_x <= '0;
      last_y <= '0;
      first <= 1'b1;
      out_valid <= 1'b0;
      out_data <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CfgSens) sens <= cfg_wdata;
        else speed <= cfg_wdata;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) item <= in_data;
        S_ANGLE: begin
          k <= speed * item.delta_time;
          wcnt <= 4'(WrapTop);
          wr <= ysum[35] ? ysum + (36'(FullTurn) <<< (WrapTop - 1)) : ysum;
          if (item.mode == ModeMouse) begin
            first <= 1'b0;
            last_x <= item.cursor_x;
            last_y <= item.cursor_y;
            if (psum > 36'(PitchLimit)) pitch <= 24'(PitchLimit);
            else if (psum < -36'(PitchLimit)) pitch <= 24'(-PitchLimit);
            else pitch <= psum[23:0];
          end
        end
        S_WRAP: begin
          wr <= wr_next;
          wcnt <= wcnt - 1'b1;
          if (wcnt == '0) yaw <= 26'(wr_next - 36'(HalfTurn));
        end
        S_CYAW: if (!crsp.busy) begin
          sy <= crsp.s;
          cy <= crsp.c;
        end
        S_CPIT: if (!crsp.busy) begin
          sp <= crsp.s;
          cp <= crsp.c;
        end
        S_PROD: begin
          fx <= mul15(cy, cp);
          fz <= mul15(sy, cp);
          ux <= neg16(mul15(cy, sp));
          uz <= neg16(mul15(sy, sp));
        end
        S_MOVE: if (mv) begin
          for (int j = 0; j < 3; j++) begin
            if (np[j] > 33'sd2147483647) pos[j] <= 32'sh7fffffff;
            else if (np[j] < -33'sd2147483648) pos[j] <= 32'sh80000000;
            else pos[j] <= np[j][31:0];
          end
        end
        S_DONE: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          out_data <= view;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    view.pos_x = pos[0];
    view.pos_y = pos[1];
    view.pos_z = pos[2];
    view.front_x = fx;
    view.front_y = sp;
    view.front_z = fz;
    view.right_x = neg16(sy);
    view.right_z = cy;
    view.up_x = ux;
    view.up_y = cp;
    view.up_z = uz;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while waiting");
  a_pitch_lim: assert property (@(posedge clk) disable iff (rst)
    (pitch <= 24'(PitchLimit)) && (pitch >= 24'(-PitchLimit)))
    else $error("pitch out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    crsp.busy |-> !in_ready)
    else $error("accept while cordic busy");

endmodule
`default_nettype wire

@@ rtl/mlc_cordic.sv @@
`default_nettype none
module mlc_cordic
  import mlc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire cordic_req_t req,
  output cordic_rsp_t rsp
);

  logic signed [33:0] x, y;
  logic signed [26:0] z;
  logic neg;
  logic busy;
  logic [StepW-1:0] step;
  logic signed [33:0] xs, ys;
  logic signed [33:0] xr, yr;
  logic signed [15:0] s_q, c_q;

  assign xs = x >>> step;
  assign ys = y >>> step;
  assign xr = neg ? -x : x;
  assign yr = neg ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= '0;
      x <= CordicX0;
      y <= '0;
      if (req.angle > QuarterTurn) begin
        z <= req.angle - HalfTurn;
        neg <= 1'b1;
      end else if (req.angle < -QuarterTurn) begin
        z <= req.angle + HalfTurn;
        neg <= 1'b1;
      end else begin
        z <= req.angle;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (step == StepW'(CordicSteps)) begin
        busy <= 1'b0;
        c_q <= sat16((36'(xr) + 36'sd16384) >>> 15);
        s_q <= sat16((36'(yr) + 36'sd16384) >>> 15);
      end else begin
        if (!z[26]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - 27'(atan_deg(5'(step)));
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + 27'(atan_deg(5'(step)));
        end
        step <= step + 1'b1;
      end
    end
  end

  assign rsp = '{busy: busy | req.start, s: s_q, c: c_q};

endmodule
`default_nettype wire
